/* sv/dtq_pkg.sv */
// Package for the deadline timer queue: operation and result codes, the
// stored entry type and fixed constants. No dependencies.
package dtq_pkg;

    localparam logic [1:0] OP_RESERVE    = 2'd0;
    localparam logic [1:0] OP_DISTRIBUTE = 2'd1;
    localparam logic [1:0] OP_CLEAR      = 2'd2;

    localparam logic [2:0] KIND_RESERVED = 3'd0;
    localparam logic [2:0] KIND_REJECTED = 3'd1;
    localparam logic [2:0] KIND_RELEASED = 3'd2;
    localparam logic [2:0] KIND_NONE     = 3'd3;
    localparam logic [2:0] KIND_CLEARED  = 3'd4;

    localparam int MAX_RESULTS = 32;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    localparam logic [23:0] CPM_RESET = 24'd10000;

    typedef struct packed {
        logic [63:0] deadline;
        logic [15:0] handle;
    } t_entry;

endpackage

/* sv/dtq_if.sv */
// Channel interfaces of the deadline timer queue: request and result.
// Depends on nothing.
interface dtq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] current_time;
    logic [31:0] delay_ms;
    logic [15:0] job_handle;

    modport source (output valid, operation, current_time, delay_ms, job_handle,
                    input ready);
    modport sink   (input valid, operation, current_time, delay_ms, job_handle,
                    output ready);
endinterface

interface dtq_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [15:0] released_handle;
    logic [5:0]  pending_count;
    logic        last_of_run;

    modport source (output valid, result_kind, released_handle, pending_count,
                    last_of_run, input ready);
    modport sink   (input valid, result_kind, released_handle, pending_count,
                    last_of_run, output ready);
endinterface

/* sv/deadline_timer_queue.sv */
// Deadline timer queue: jobs kept sorted by deadline in a circular buffer
// held in one synchronous memory; release pops from the head.
// Depends on dtq_pkg, dtq_if, dtq_mem and dtq_due.
//
// One item at a time. A reserve passes through S_MUL and S_INS0; a full
// queue rejects it there, an empty one goes on to S_PUT, and otherwise S_CMP
// moves each queued job with a later deadline up one slot through the
// memory's single write port and finds the insert point, unless every queued
// job moves; then S_PUT writes the new job. A distribute pops due jobs from
// the head in S_DIS, and a clear goes straight to S_OUT. A result waits in an
// output register while the next item is accepted; the block only stalls when
// a new result finds that register still full. counts_per_ms is written
// through i_cfg_we/i_cfg_wdata.
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtq_req_if.sink     i_req,
    dtq_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_INS0 = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;
    localparam logic [2:0] S_DIS  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [23:0]     r_cpm;
    logic [CW-1:0]   r_occ, n_occ;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_pos, n_pos;
    logic [dtq_pkg::NW-1:0] r_n, n_n;
    logic            r_havep, n_havep;
    logic [15:0]     r_pend_h, n_pend_h;
    logic [63:0]     r_now;
    logic [15:0]     r_handle;
    logic [2:0]      r_kind, n_kind;

    logic            r_ovalid;
    logic [2:0]      r_okind;
    logic [15:0]     r_ohandle;
    logic [5:0]      r_ocnt;
    logic            r_olast;

    logic            o_load;
    logic [2:0]      o_kind;
    logic [15:0]     o_handle;
    logic            o_last;

    logic            accept, out_free, due_now;
    logic [63:0]     due;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    dtq_pkg::t_entry wdata, rdata;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(k);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free = !r_ovalid || o_res.ready;

    dtq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dtq_due u_due (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_now   (i_req.current_time),
        .i_delay (i_req.delay_ms),
        .i_cpm   (r_cpm),
        .o_due   (due)
    );

    assign due_now = (r_occ != '0) && (rdata.deadline <= r_now) &&
                     (r_n < dtq_pkg::NW'(dtq_pkg::MAX_RESULTS));

    always_comb begin
        n_state  = r_state;
        n_occ    = r_occ;
        n_head   = r_head;
        n_pos    = r_pos;
        n_n      = r_n;
        n_havep  = r_havep;
        n_pend_h = r_pend_h;
        n_kind   = r_kind;
        we       = 1'b0;
        waddr    = phys(r_head, r_pos);
        wdata    = rdata;
        raddr    = r_head;
        o_load   = 1'b0;
        o_kind   = r_kind;
        o_handle = '0;
        o_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.operation)
                        dtq_pkg::OP_RESERVE: n_state = S_MUL;
                        dtq_pkg::OP_DISTRIBUTE: begin
                            n_n     = '0;
                            n_havep = 1'b0;
                            n_state = S_DIS;
                        end
                        dtq_pkg::OP_CLEAR: begin
                            n_occ   = '0;
                            n_head  = '0;
                            n_kind  = dtq_pkg::KIND_CLEARED;
                            n_state = S_OUT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: n_state = S_INS0;
            S_INS0: begin
                if (r_occ == CW'(QUEUE_DEPTH)) begin
                    n_kind  = dtq_pkg::KIND_REJECTED;
                    n_state = S_OUT;
                end else if (r_occ == '0) begin
                    n_pos   = '0;
                    n_state = S_PUT;
                end else begin
                    raddr   = phys(r_head, r_occ - 1'b1);
                    n_pos   = r_occ;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // Shift later entries up one slot until the insert point.
                if (rdata.deadline > due) begin
                    we    = 1'b1;
                    n_pos = r_pos - 1'b1;
                    if (r_pos == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        raddr = phys(r_head, r_pos - CW'(2));
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                we             = 1'b1;
                wdata.deadline = due;
                wdata.handle   = r_handle;
                n_occ          = r_occ + 1'b1;
                n_kind         = dtq_pkg::KIND_RESERVED;
                n_state        = S_OUT;
            end
            S_DIS: begin
                // A popped job is held back in r_pend_h so that its last flag
                // can see whether the next head is also due.
                if (out_free) begin
                    if (r_havep) begin
                        o_load   = 1'b1;
                        o_kind   = dtq_pkg::KIND_RELEASED;
                        o_handle = r_pend_h;
                        o_last   = !due_now;
                    end else if (!due_now) begin
                        o_load = 1'b1;
                        o_kind = dtq_pkg::KIND_NONE;
                    end
                    if (due_now) begin
                        n_pend_h = rdata.handle;
                        n_havep  = 1'b1;
                        n_head   = phys(r_head, CW'(1));
                        raddr    = phys(r_head, CW'(1));
                        n_occ    = r_occ - 1'b1;
                        n_n      = r_n + 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cpm    <= dtq_pkg::CPM_RESET;
            r_occ    <= '0;
            r_head   <= '0;
            r_havep  <= 1'b0;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_head  <= n_head;
            r_havep <= n_havep;
            r_n     <= n_n;
            if (i_cfg_we) begin
                r_cpm <= i_cfg_wdata;
            end
            if (o_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // The count of the current cycle already covers the job being reported.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_pend_h <= n_pend_h;
        r_kind   <= n_kind;
        if (accept) begin
            r_now    <= i_req.current_time;
            r_handle <= i_req.job_handle;
        end
        if (o_load) begin
            r_okind   <= o_kind;
            r_ohandle <= o_handle;
            r_ocnt    <= 6'(r_occ);
            r_olast   <= o_last;
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.result_kind     = r_okind;
    assign o_res.released_handle = r_ohandle;
    assign o_res.pending_count   = r_ocnt;
    assign o_res.last_of_run     = r_olast;
endmodule

/* sv/dtq_mem.sv */
// Entry memory of the deadline timer queue: one write port, one read port
// with registered read data. Depends on dtq_pkg.
module dtq_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  dtq_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output dtq_pkg::t_entry   o_rdata
);
    dtq_pkg::t_entry r_mem [DEPTH];
    dtq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/dtq_due.sv */
// Deadline computation: delay times counts per ms, then a saturating add
// to the current time, one register after each step. Depends on nothing.
module dtq_due (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [63:0] i_now,
    input  logic [31:0] i_delay,
    input  logic [23:0] i_cpm,
    output logic [63:0] o_due
);
    logic [55:0] r_prod;
    logic [63:0] r_now;
    logic [63:0] r_due;
    logic [64:0] n_sum;

    assign n_sum = {1'b0, r_now} + 65'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= 56'(i_delay) * 56'(i_cpm);
            r_now  <= i_now;
        end
        r_due <= n_sum[64] ? '1 : n_sum[63:0];
    end

    assign o_due = r_due;
endmodule

/* verif/dtq_checker.sv */
// Checker for the deadline timer queue: watches request and result channels,
// predicts results from its own sorted job list. Depends on dtq_pkg, dtq_if.
module dtq_checker #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtq_req_if          req,
    dtq_res_if          res,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] handle;
        logic [5:0]  pending;
        logic        last;
    } t_result;

    dtq_pkg::t_entry jobs[$];
    t_result expected_results[$];
    logic [23:0] counts_per_ms;
    int fails;

    assign o_fail_count = fails;
    assign o_pending_results = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("%0t MISMATCH: %s", $realtime, what);
        fails++;
    endtask

    function automatic t_result make_result(logic [2:0] k, logic [15:0] h, int n,
                                            logic l);
        t_result r;
        r.kind = k;
        r.handle = h;
        r.pending = n[5:0];
        r.last = l;
        return r;
    endfunction

    function automatic void add_expected(input t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic predict_item(input logic [1:0] op, input logic [63:0] now,
                                input logic [31:0] delay, input logic [15:0] h);
        logic [64:0] due;
        dtq_pkg::t_entry e;
        int pos;
        int n;
        case (op)
            dtq_pkg::OP_RESERVE: begin
                due = {1'b0, now} + 65'(64'(delay) * 64'(counts_per_ms));
                if (jobs.size() >= QUEUE_DEPTH) begin
                    add_expected(make_result(dtq_pkg::KIND_REJECTED, 16'd0,
                                             jobs.size(), 1'b1));
                end else begin
                    e.deadline = due[64] ? '1 : due[63:0];
                    e.handle = h;
                    pos = jobs.size();
                    while (pos > 0 && jobs[pos-1].deadline > e.deadline) pos--;
                    jobs.insert(pos, e);
                    add_expected(make_result(dtq_pkg::KIND_RESERVED, 16'd0,
                                             jobs.size(), 1'b1));
                end
            end
            dtq_pkg::OP_DISTRIBUTE: begin
                if (jobs.size() == 0 || jobs[0].deadline > now) begin
                    add_expected(make_result(dtq_pkg::KIND_NONE, 16'd0,
                                             jobs.size(), 1'b1));
                end else begin
                    n = 0;
                    while (n < dtq_pkg::MAX_RESULTS && jobs.size() > 0
                           && jobs[0].deadline <= now) begin
                        e = jobs.pop_front();
                        n++;
                        add_expected(make_result(dtq_pkg::KIND_RELEASED, e.handle,
                            jobs.size(),
                            !(n < dtq_pkg::MAX_RESULTS && jobs.size() > 0
                              && jobs[0].deadline <= now)));
                    end
                end
            end
            dtq_pkg::OP_CLEAR: begin
                jobs.delete();
                add_expected(make_result(dtq_pkg::KIND_CLEARED, 16'd0, 0, 1'b1));
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            jobs.delete();
            expected_results.delete();
            counts_per_ms <= dtq_pkg::CPM_RESET;
            fails = 0;
        end else begin
            if (i_cfg_we) counts_per_ms <= i_cfg_wdata;
            if (req.valid && req.ready)
                predict_item(req.operation, req.current_time, req.delay_ms,
                             req.job_handle);
            if (res.valid && res.ready) begin
                got = make_result(res.result_kind, res.released_handle,
                                  int'(res.pending_count), res.last_of_run);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
                    if (got.handle !== want.handle)
                        report_mismatch($sformatf("handle %0h want %0h", got.handle,
                                                  want.handle));
                    if (got.pending !== want.pending)
                        report_mismatch($sformatf("pending %0d want %0d", got.pending,
                                                  want.pending));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
                end
            end
        end
    end
endmodule

/* verif/tb_deadline_timer_queue.sv */
// Top of the deadline timer queue testbench: clock, reset, stimulus and verdict.
// Depends on dtq_pkg, dtq_if, the block and dtq_checker.
module tb_deadline_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    // The one operation code that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [23:0] cfg_wdata = '0;
    int          fail_count;
    int          results_due;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    logic [63:0] clock_now = 64'd1000;

    dtq_req_if req();
    dtq_res_if res();

    deadline_timer_queue #(.QUEUE_DEPTH(32)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_res(res),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    dtq_checker #(.QUEUE_DEPTH(32)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .res(res),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending_results(results_due)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side drops ready in random bursts until the calm tail.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    // Valid stays high after an accepted transaction only until the next call
    // in the same time step replaces it, or a gap or wait drops it.
    task automatic send_item(input logic [1:0] op, input logic [63:0] now,
                             input logic [31:0] delay, input logic [15:0] h);
        int gap;
        logic took;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.current_time <= now;
        req.delay_ms <= delay;
        req.job_handle <= h;
        do begin
            @(negedge i_clk);
            took = req.ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [23:0] value);
        wait_drained();
        repeat (80) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        logic [63:0] t;
        pick = $urandom_range(0, 99);
        clock_now = clock_now + 64'($urandom_range(0, 40));
        t = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_now;
        if (pick < 55)
            send_item(dtq_pkg::OP_RESERVE, t, ($urandom_range(0, 9) == 0) ? $urandom
                      : $urandom_range(0, 3), 16'($urandom));
        else if (pick < 90)
            send_item(dtq_pkg::OP_DISTRIBUTE, t, $urandom, 16'($urandom));
        else if (pick < 95)
            send_item(dtq_pkg::OP_CLEAR, t, $urandom, 16'($urandom));
        else
            send_item(OP_UNUSED, t, $urandom, 16'($urandom));
    endtask

    initial begin
        req.valid = 1'b0;
        req.operation = dtq_pkg::OP_RESERVE;
        req.current_time = '0;
        req.delay_ms = '0;
        req.job_handle = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty release, extremes, overflow, ties, full queue, bursts.
        send_item(dtq_pkg::OP_DISTRIBUTE, 64'd0, 32'd0, 16'd0);
        send_item(dtq_pkg::OP_RESERVE, '1, '1, 16'hFFFF);
        send_item(dtq_pkg::OP_RESERVE, 64'd0, 32'd0, 16'h0000);
        send_item(dtq_pkg::OP_RESERVE, 64'd0, 32'd0, 16'h5555);
        send_item(dtq_pkg::OP_RESERVE, 64'd0, 32'd0, 16'hAAAA);
        send_item(dtq_pkg::OP_DISTRIBUTE, 64'd0, '1, 16'hFFFF);
        send_item(OP_UNUSED, '1, '1, 16'hFFFF);
        send_item(dtq_pkg::OP_DISTRIBUTE, '1, 32'd0, 16'd0);
        for (int i = 0; i < 34; i++)
            send_item(dtq_pkg::OP_RESERVE, 64'd100, 32'(i % 3), 16'(i));
        send_item(dtq_pkg::OP_DISTRIBUTE, '1, 32'd0, 16'd0);
        send_item(dtq_pkg::OP_RESERVE, 64'd5, 32'd1, 16'h1234);
        send_item(dtq_pkg::OP_CLEAR, '1, '1, 16'hFFFF);

        write_rate(24'd0);
        for (int i = 0; i < 40; i++) random_item();
        write_rate(24'hFFFFFF);
        for (int i = 0; i < 40; i++) random_item();
        write_rate(24'd1);
        for (int i = 0; i < 80; i++) random_item();
        write_rate(24'd7);
        for (int i = 0; i < 80; i++) random_item();
        calm = 1'b1;
        for (int i = 0; i < 40; i++) random_item();

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
